[hdl/articulation_point_finder_assert.svh]
// assertion macros for the articulation point finder
// used by the top level; needs i_clk and i_rst_n in scope
`ifndef ARTICULATION_POINT_FINDER_ASSERT_SVH
`define ARTICULATION_POINT_FINDER_ASSERT_SVH

// implication checked at every clock edge outside reset
`define APF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// plain condition that must hold at every clock edge outside reset
`define APF_ALWAYS(lbl, cond, msg) \
    `APF_ASSERT(lbl, (1'b1 |-> (cond)), msg)

`endif

[hdl/apf_pkg.sv]
// shared constants, codes and types of the articulation point finder
// no dependencies
`default_nettype none

package apf_pkg;

    localparam int MAX_NODES   = 256;
    localparam int MAX_EDGES   = 2048;
    localparam int NODE_W      = 8;
    localparam int NODE_CNT_W  = 9;
    localparam int EDGE_ADDR_W = 11;
    localparam int EDGE_CNT_W  = 12;

    localparam logic [NODE_CNT_W-1:0] NO_PARENT = NODE_CNT_W'(MAX_NODES);
    localparam logic [NODE_CNT_W-1:0] NODE_LIMIT = NODE_CNT_W'(MAX_NODES);
    localparam logic [EDGE_CNT_W-1:0] EDGE_LIMIT = EDGE_CNT_W'(MAX_EDGES);

    // item modes
    localparam logic [2:0] MODE_RESET   = 3'd0;
    localparam logic [2:0] MODE_DECLARE = 3'd1;
    localparam logic [2:0] MODE_ADD     = 3'd2;
    localparam logic [2:0] MODE_COMPUTE = 3'd3;
    localparam logic [2:0] MODE_QUERY   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // per node walk record
    typedef struct packed {
        logic [NODE_W-1:0]     disc;
        logic [NODE_W-1:0]     low;
        logic [NODE_CNT_W-1:0] parent;
        logic [EDGE_CNT_W-1:0] scan;
        logic [EDGE_CNT_W-1:0] lend;
        logic                  skip;
    } t_node_rec;

    typedef struct packed {
        logic start;
        logic clear_cuts;
    } t_walk_ctl;

    typedef struct packed {
        logic                  done;
        logic [NODE_CNT_W-1:0] cut_total;
    } t_walk_sts;

endpackage

`default_nettype wire

[hdl/apf_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/apf_walk.sv]
// depth-first walk sequencer: discovery and low values, cut flags
// depends on apf_pkg and apf_ram (node record memory)
`default_nettype none

module apf_walk (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire apf_pkg::t_walk_ctl                  i_ctl,
    output apf_pkg::t_walk_sts                       o_sts,
    input  wire logic [apf_pkg::NODE_CNT_W-1:0]      i_node_total,
    input  wire logic [apf_pkg::MAX_NODES-1:0]       i_sel,
    output logic      [apf_pkg::EDGE_ADDR_W-1:0]     o_nbr_raddr,
    input  wire logic [apf_pkg::NODE_W-1:0]          i_nbr_rdata,
    output logic      [apf_pkg::NODE_W-1:0]          o_list_raddr,
    input  wire logic [2*apf_pkg::EDGE_CNT_W-1:0]    i_list_rdata,
    input  wire logic [apf_pkg::NODE_W-1:0]          i_query_idx,
    output logic                                     o_query_cut
);

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_ROOT = 3'd1;
    localparam logic [2:0] W_LOAD = 3'd2;
    localparam logic [2:0] W_SCAN = 3'd3;
    localparam logic [2:0] W_EVAL = 3'd4;
    localparam logic [2:0] W_DISC = 3'd5;
    localparam logic [2:0] W_POP  = 3'd6;

    localparam int REC_W = $bits(apf_pkg::t_node_rec);

    logic [2:0]                       r_state;
    logic [apf_pkg::NODE_CNT_W-1:0]   r_s;
    logic [apf_pkg::NODE_W-1:0]       r_u;
    logic [apf_pkg::NODE_W-1:0]       r_nxt;
    logic                             r_root_ld;
    logic [1:0]                       r_rc;
    logic [apf_pkg::NODE_CNT_W-1:0]   r_vc;
    logic [apf_pkg::MAX_NODES-1:0]    r_vis;
    logic [apf_pkg::MAX_NODES-1:0]    r_cut;
    logic [apf_pkg::NODE_CNT_W-1:0]   r_cut_total;
    apf_pkg::t_node_rec               r_rec;

    logic                             rec_we;
    logic [apf_pkg::NODE_W-1:0]       rec_waddr;
    apf_pkg::t_node_rec               rec_wdata;
    logic [apf_pkg::NODE_W-1:0]       rec_raddr;
    apf_pkg::t_node_rec               rec_rdata;
    apf_pkg::t_node_rec               new_rec;
    apf_pkg::t_node_rec               pop_rec;
    logic [apf_pkg::NODE_W-1:0]       w;
    logic                             w_ok;
    logic                             w_parent_skip;
    logic                             w_descend;
    logic                             scan_more;
    logic                             root_done;
    logic [apf_pkg::NODE_W-1:0]       s_idx;

    assign w         = i_nbr_rdata;
    assign s_idx     = r_s[apf_pkg::NODE_W-1:0];
    assign w_ok      = ({1'b0, w} < i_node_total) && i_sel[w];
    assign w_parent_skip = ({1'b0, w} == r_rec.parent) && !r_rec.skip;
    assign w_descend = w_ok && !w_parent_skip && !r_vis[w];
    assign scan_more = r_rec.scan < r_rec.lend;
    assign root_done = r_s >= i_node_total;

    // record of a freshly discovered node
    always_comb begin
        new_rec.disc   = r_vc[apf_pkg::NODE_W-1:0];
        new_rec.low    = r_vc[apf_pkg::NODE_W-1:0];
        new_rec.parent = r_root_ld ? apf_pkg::NO_PARENT : {1'b0, r_u};
        new_rec.scan   = i_list_rdata[2*apf_pkg::EDGE_CNT_W-1:apf_pkg::EDGE_CNT_W];
        new_rec.lend   = i_list_rdata[apf_pkg::EDGE_CNT_W-1:0];
        new_rec.skip   = 1'b0;
    end

    // parent record with the child low folded in
    always_comb begin
        pop_rec = rec_rdata;
        if (r_rec.low < rec_rdata.low) begin
            pop_rec.low = r_rec.low;
        end
    end

    // memory addressing per state
    always_comb begin
        rec_we       = 1'b0;
        rec_waddr    = r_u;
        rec_wdata    = r_rec;
        rec_raddr    = r_u;
        o_nbr_raddr  = r_rec.scan[apf_pkg::EDGE_ADDR_W-1:0];
        o_list_raddr = s_idx;
        case (r_state)
            W_LOAD: begin
                rec_we    = 1'b1;
                rec_waddr = r_nxt;
                rec_wdata = new_rec;
            end
            W_EVAL: begin
                o_list_raddr = w;
                rec_raddr    = w;
                rec_we       = w_descend;
            end
            W_SCAN: begin
                rec_raddr = r_rec.parent[apf_pkg::NODE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    apf_ram #(
        .WIDTH(REC_W),
        .DEPTH(apf_pkg::MAX_NODES)
    ) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(rec_waddr),
        .i_wdata(rec_wdata),
        .i_raddr(rec_raddr),
        .o_rdata(rec_rdata)
    );

    // walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= W_IDLE;
            r_vis       <= '0;
            r_cut       <= '0;
            r_cut_total <= '0;
            r_s         <= '0;
            r_vc        <= '0;
            r_rc        <= '0;
            r_root_ld   <= 1'b0;
        end else begin
            case (r_state)
                W_IDLE: begin
                    if (i_ctl.clear_cuts) begin
                        r_cut       <= '0;
                        r_cut_total <= '0;
                    end
                    if (i_ctl.start) begin
                        r_vis       <= '0;
                        r_cut       <= '0;
                        r_cut_total <= '0;
                        r_vc        <= '0;
                        r_s         <= '0;
                        r_state     <= W_ROOT;
                    end
                end
                W_ROOT: begin
                    if (root_done) begin
                        r_state <= W_IDLE;
                    end else if (i_sel[s_idx] && !r_vis[s_idx]) begin
                        r_nxt     <= s_idx;
                        r_root_ld <= 1'b1;
                        r_rc      <= '0;
                        r_state   <= W_LOAD;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                W_LOAD: begin
                    r_u          <= r_nxt;
                    r_rec        <= new_rec;
                    r_vis[r_nxt] <= 1'b1;
                    r_vc         <= r_vc + 1'b1;
                    r_state      <= W_SCAN;
                end
                W_SCAN: begin
                    if (scan_more) begin
                        r_rec.scan <= r_rec.scan + 1'b1;
                        r_state    <= W_EVAL;
                    end else if (r_rec.parent == apf_pkg::NO_PARENT) begin
                        // root finished: more than one tree child makes it a cut
                        if (r_rc[1] && !r_cut[s_idx]) begin
                            r_cut[s_idx] <= 1'b1;
                            r_cut_total  <= r_cut_total + 1'b1;
                        end
                        r_s     <= r_s + 1'b1;
                        r_state <= W_ROOT;
                    end else begin
                        r_state <= W_POP;
                    end
                end
                W_EVAL: begin
                    if (!w_ok) begin
                        r_state <= W_SCAN;
                    end else if (w_parent_skip) begin
                        r_rec.skip <= 1'b1;
                        r_state    <= W_SCAN;
                    end else if (!r_vis[w]) begin
                        if (r_rec.parent == apf_pkg::NO_PARENT && !r_rc[1]) begin
                            r_rc <= r_rc + 1'b1;
                        end
                        r_nxt     <= w;
                        r_root_ld <= 1'b0;
                        r_state   <= W_LOAD;
                    end else begin
                        r_state <= W_DISC;
                    end
                end
                W_DISC: begin
                    if (rec_rdata.disc < r_rec.low) begin
                        r_rec.low <= rec_rdata.disc;
                    end
                    r_state <= W_SCAN;
                end
                W_POP: begin
                    // back to the parent, fold child low into it
                    r_rec <= pop_rec;
                    if (rec_rdata.parent != apf_pkg::NO_PARENT
                        && r_rec.low >= rec_rdata.disc
                        && !r_cut[r_rec.parent[apf_pkg::NODE_W-1:0]]) begin
                        r_cut[r_rec.parent[apf_pkg::NODE_W-1:0]] <= 1'b1;
                        r_cut_total <= r_cut_total + 1'b1;
                    end
                    r_u     <= r_rec.parent[apf_pkg::NODE_W-1:0];
                    r_state <= W_SCAN;
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done      = (r_state == W_ROOT) && root_done;
    assign o_sts.cut_total = r_cut_total;
    assign o_query_cut     = r_cut[i_query_idx];

endmodule

`default_nettype wire

[hdl/articulation_point_finder.sv]
// top level: graph loading, query and result register of the cut vertex finder
// depends on apf_pkg, apf_ram, apf_walk and articulation_point_finder_assert.svh
//
// use: items arrive on the slave stream, tuser carries the mode (reset graph,
// declare node, add neighbor, compute, query node), tdata the node, select bit,
// neighbor and node count. every item gives exactly one result on the master
// stream: tuser holds the status, tdata the cut flag and the cut count.
// load, query and reset items finish in the accept cycle; the result is valid
// from the next cycle, and with the receiver ready the next item is taken in
// that same cycle, so these items can run one per cycle.
// a compute item walks the selected subgraph depth first through the record,
// neighbor and list memories: it tries each node as a root, scans each list
// entry (with a further check when it meets a visited node) and loads and
// pops each tree node, paced by the registered-read record memory and the
// edge scan; no item is accepted meanwhile.
// a result that the receiver does not take stays in the output register; a
// new item is accepted only when that register is free or being emptied.
// after reset the graph is empty, no node selected, all cut flags clear.
`default_nettype none

module articulation_point_finder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [7:0] node_index, [8] node_is_selected, [16:9] neighbor_index,
    // [25:17] graph_node_count, [31:26] zero
    input  wire logic [31:0] i_s_tdata,
    // [2:0] mode
    input  wire logic [2:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] is_cut_vertex, [9:1] cut_vertex_count, [15:10] zero
    output logic      [15:0] o_m_tdata,
    // [1:0] status
    output logic      [1:0]  o_m_tuser
);

    `include "articulation_point_finder_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]                        r_state;
    logic [apf_pkg::NODE_CNT_W-1:0]    r_node_total;
    logic [apf_pkg::EDGE_CNT_W-1:0]    r_fill;
    logic [apf_pkg::NODE_W-1:0]        r_owner;
    logic [apf_pkg::EDGE_CNT_W-1:0]    r_owner_start;
    logic [apf_pkg::MAX_NODES-1:0]     r_sel;
    logic                              r_ovalid;
    logic [1:0]                        r_ostatus;
    logic                              r_ocut;

    logic [2:0]                        in_mode;
    logic [apf_pkg::NODE_W-1:0]        in_node;
    logic                              in_sel;
    logic [apf_pkg::NODE_W-1:0]        in_nbr;
    logic [apf_pkg::NODE_CNT_W-1:0]    in_count;
    logic                              accept;
    logic                              out_free;

    logic                              nbr_we;
    logic                              list_we;
    logic [apf_pkg::NODE_W-1:0]        list_waddr;
    logic [2*apf_pkg::EDGE_CNT_W-1:0]  list_wdata;
    logic [apf_pkg::EDGE_ADDR_W-1:0]   nbr_raddr;
    logic [apf_pkg::NODE_W-1:0]        nbr_rdata;
    logic [apf_pkg::NODE_W-1:0]        list_raddr;
    logic [2*apf_pkg::EDGE_CNT_W-1:0]  list_rdata;
    logic                              query_cut;
    logic                              add_ok;
    logic                              add_room;
    apf_pkg::t_walk_ctl                walk_ctl;
    apf_pkg::t_walk_sts                walk_sts;

    assign in_mode  = i_s_tuser;
    assign in_node  = i_s_tdata[7:0];
    assign in_sel   = i_s_tdata[8];
    assign in_nbr   = i_s_tdata[16:9];
    assign in_count = i_s_tdata[25:17];

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // neighbor append checks
    assign add_ok   = ({1'b0, r_owner} < r_node_total) && ({1'b0, in_nbr} < r_node_total);
    assign add_room = r_fill < apf_pkg::EDGE_LIMIT;

    // store writes for declare and add
    always_comb begin
        nbr_we     = 1'b0;
        list_we    = 1'b0;
        list_waddr = in_node;
        list_wdata = {r_fill, r_fill};
        if (accept) begin
            case (in_mode)
                apf_pkg::MODE_DECLARE: begin
                    list_we = {1'b0, in_node} < r_node_total;
                end
                apf_pkg::MODE_ADD: begin
                    nbr_we     = add_ok && add_room;
                    list_we    = add_ok && add_room;
                    list_waddr = r_owner;
                    list_wdata = {r_owner_start, r_fill + 1'b1};
                end
                default: begin
                end
            endcase
        end
    end

    assign walk_ctl.start      = accept && (in_mode == apf_pkg::MODE_COMPUTE);
    assign walk_ctl.clear_cuts = accept && (in_mode == apf_pkg::MODE_RESET);

    apf_ram #(
        .WIDTH(apf_pkg::NODE_W),
        .DEPTH(apf_pkg::MAX_EDGES)
    ) u_nbr_ram (
        .i_clk  (i_clk),
        .i_we   (nbr_we),
        .i_waddr(r_fill[apf_pkg::EDGE_ADDR_W-1:0]),
        .i_wdata(in_nbr),
        .i_raddr(nbr_raddr),
        .o_rdata(nbr_rdata)
    );

    apf_ram #(
        .WIDTH(2*apf_pkg::EDGE_CNT_W),
        .DEPTH(apf_pkg::MAX_NODES)
    ) u_list_ram (
        .i_clk  (i_clk),
        .i_we   (list_we),
        .i_waddr(list_waddr),
        .i_wdata(list_wdata),
        .i_raddr(list_raddr),
        .o_rdata(list_rdata)
    );

    apf_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (walk_ctl),
        .o_sts       (walk_sts),
        .i_node_total(r_node_total),
        .i_sel       (r_sel),
        .o_nbr_raddr (nbr_raddr),
        .i_nbr_rdata (nbr_rdata),
        .o_list_raddr(list_raddr),
        .i_list_rdata(list_rdata),
        .i_query_idx (in_node),
        .o_query_cut (query_cut)
    );

    // item handling and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_node_total  <= '0;
            r_fill        <= '0;
            r_owner       <= '0;
            r_owner_start <= '0;
            r_sel         <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= apf_pkg::ST_OK;
                        r_ocut    <= 1'b0;
                        case (in_mode)
                            apf_pkg::MODE_RESET: begin
                                r_fill        <= '0;
                                r_owner       <= '0;
                                r_owner_start <= '0;
                                r_sel         <= '0;
                                if (in_count > apf_pkg::NODE_LIMIT) begin
                                    r_node_total <= apf_pkg::NODE_LIMIT;
                                    r_ostatus    <= apf_pkg::ST_RANGE;
                                end else begin
                                    r_node_total <= in_count;
                                end
                            end
                            apf_pkg::MODE_DECLARE: begin
                                if ({1'b0, in_node} < r_node_total) begin
                                    r_sel[in_node] <= in_sel;
                                    r_owner        <= in_node;
                                    r_owner_start  <= r_fill;
                                end else begin
                                    r_ostatus <= apf_pkg::ST_RANGE;
                                end
                            end
                            apf_pkg::MODE_ADD: begin
                                if (!add_ok) begin
                                    r_ostatus <= apf_pkg::ST_RANGE;
                                end else if (!add_room) begin
                                    r_ostatus <= apf_pkg::ST_FULL;
                                end else begin
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                            apf_pkg::MODE_COMPUTE: begin
                                r_ovalid <= 1'b0;
                                r_state  <= S_BUSY;
                            end
                            apf_pkg::MODE_QUERY: begin
                                if ({1'b0, in_node} < r_node_total) begin
                                    r_ocut <= query_cut;
                                end else begin
                                    r_ostatus <= apf_pkg::ST_RANGE;
                                end
                            end
                            default: begin
                                r_ostatus <= apf_pkg::ST_RANGE;
                            end
                        endcase
                    end
                end
                S_BUSY: begin
                    if (walk_sts.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= apf_pkg::ST_OK;
                        r_ocut    <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = {6'd0, walk_sts.cut_total, r_ocut};

    // checks on the sequencing
    `APF_ASSERT(a_busy_no_accept, (r_state != S_IDLE) |-> !o_s_tready,
                "item taken while busy")
    `APF_ASSERT(a_compute_enters_busy,
                (accept && in_mode == apf_pkg::MODE_COMPUTE) |=> (r_state == S_BUSY),
                "compute did not start")
    `APF_ALWAYS(a_cut_count_bound, walk_sts.cut_total <= apf_pkg::NODE_LIMIT,
                "cut count overflow")
    `APF_ALWAYS(a_fill_bound, r_fill <= apf_pkg::EDGE_LIMIT, "edge fill past store")

endmodule

`default_nettype wire

[tb/sv/apf_checker.sv]
// result checker of the articulation point finder: watches both streams,
// predicts each result from its own copy of the graph and compares
// depends on apf_pkg
`default_nettype none

module apf_checker
    import apf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,
    input  wire logic [2:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0]            status;
        logic                  cut;
        logic [NODE_CNT_W-1:0] cut_count;
    } t_answer;

    // graph image
    logic [7:0]  nbr_mem [MAX_EDGES];
    int          lst_lo [MAX_NODES];
    int          lst_hi [MAX_NODES];
    bit          sel [MAX_NODES];
    bit          cut_flag [MAX_NODES];
    int          fill;
    int          owner;
    int          n_nodes;
    int          n_cuts;

    // walk scratch
    bit          seen [MAX_NODES];
    bit          skipped [MAX_NODES];
    int          disc [MAX_NODES];
    int          lowv [MAX_NODES];
    int          par [MAX_NODES];
    int          pos [MAX_NODES];
    int          stk [MAX_NODES];
    int          depth;
    int          stamp;

    t_answer     answer_q [$];

    task automatic visit(input int v, input int p);
        seen[v] = 1;
        disc[v] = stamp;
        lowv[v] = stamp;
        stamp++;
        par[v] = p;
        pos[v] = lst_lo[v];
        if (depth < MAX_NODES) begin
            stk[depth] = v;
            depth++;
        end
    endtask

    task automatic find_cuts();
        int kids;
        int u;
        int w;
        int q;
        bit pushed;
        for (int k = 0; k < MAX_NODES; k++) begin
            seen[k] = 0;
            skipped[k] = 0;
            cut_flag[k] = 0;
        end
        stamp = 0;
        n_cuts = 0;
        for (int s = 0; s < n_nodes; s++) begin
            if (!sel[s] || seen[s]) continue;
            kids = 0;
            depth = 0;
            visit(s, MAX_NODES);
            while (depth > 0) begin
                u = stk[depth-1];
                pushed = 0;
                while (pos[u] < lst_hi[u] && pos[u] < MAX_EDGES) begin
                    w = nbr_mem[pos[u]];
                    pos[u]++;
                    if (w >= n_nodes || !sel[w]) continue;
                    if (w == par[u] && !skipped[u]) begin
                        skipped[u] = 1;
                        continue;
                    end
                    if (!seen[w]) begin
                        if (par[u] == MAX_NODES) kids++;
                        visit(w, u);
                        pushed = 1;
                        break;
                    end
                    if (disc[w] < lowv[u]) lowv[u] = disc[w];
                end
                if (!pushed) begin
                    depth--;
                    if (depth > 0) begin
                        q = stk[depth-1];
                        if (lowv[u] < lowv[q]) lowv[q] = lowv[u];
                        if (par[q] != MAX_NODES && lowv[u] >= disc[q]) cut_flag[q] = 1;
                    end
                end
            end
            if (kids > 1) cut_flag[s] = 1;
        end
        for (int k = 0; k < n_nodes; k++) n_cuts += cut_flag[k];
    endtask

    task automatic clear_image();
        for (int k = 0; k < MAX_NODES; k++) begin
            lst_lo[k] = 0;
            lst_hi[k] = 0;
            sel[k] = 0;
            cut_flag[k] = 0;
        end
        fill = 0;
        owner = 0;
        n_cuts = 0;
    endtask

    // one transaction in, one expected answer
    task automatic predict(input logic [2:0] mode, input logic [31:0] d);
        int      node;
        int      nbr;
        int      cnt;
        t_answer a;
        node = d[7:0];
        nbr  = d[16:9];
        cnt  = d[25:17];
        a = '0;
        a.status = ST_OK;
        case (mode)
            MODE_RESET: begin
                clear_image();
                if (cnt > MAX_NODES) begin
                    n_nodes = MAX_NODES;
                    a.status = ST_RANGE;
                end else begin
                    n_nodes = cnt;
                end
            end
            MODE_DECLARE: begin
                if (node >= n_nodes) a.status = ST_RANGE;
                else begin
                    sel[node] = d[8];
                    lst_lo[node] = fill;
                    lst_hi[node] = fill;
                    owner = node;
                end
            end
            MODE_ADD: begin
                if (owner >= n_nodes || nbr >= n_nodes) a.status = ST_RANGE;
                else if (fill >= MAX_EDGES) a.status = ST_FULL;
                else begin
                    nbr_mem[fill] = nbr[7:0];
                    fill++;
                    lst_hi[owner] = fill;
                end
            end
            MODE_COMPUTE: find_cuts();
            MODE_QUERY: begin
                if (node >= n_nodes) a.status = ST_RANGE;
                else a.cut = cut_flag[node];
            end
            default: a.status = ST_RANGE;
        endcase
        a.cut_count = n_cuts[NODE_CNT_W-1:0];
        answer_q = {answer_q, a};
    endtask

    initial begin
        clear_image();
        n_nodes = 0;
        o_fail_count = 0;
    end

    assign o_pending = answer_q.size();

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_answer e;
        int      errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (answer_q.size() == 0) begin
                    $error("result with no transaction waiting");
                    errs++;
                end else begin
                    e = answer_q.pop_front();
                    if (i_m_tuser != e.status) begin
                        $error("status: expected %0d actual %0d", e.status, i_m_tuser);
                        errs++;
                    end
                    if (i_m_tdata[0] != e.cut) begin
                        $error("is_cut_vertex: expected %0d actual %0d", e.cut, i_m_tdata[0]);
                        errs++;
                    end
                    if (i_m_tdata[9:1] != e.cut_count) begin
                        $error("cut_vertex_count: expected %0d actual %0d",
                               e.cut_count, i_m_tdata[9:1]);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// testbench top of the articulation point finder: clock, reset, stimulus, verdict
// depends on apf_pkg, apf_checker and the articulation_point_finder rtl
`default_nettype none

module tb_top;
    import apf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    bit          calm;
    int          sent;

    articulation_point_finder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    apf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stalls, none during the calm stretch
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 19);
    end

    // one input transaction; random gap before it
    task automatic send(input logic [2:0] mode, input int node, input bit sel_bit,
                        input int nbr, input int cnt);
        while (!calm && $urandom_range(99) < 19) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, 9'(cnt), 8'(nbr), sel_bit, 8'(node)};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    // random graph: mostly valid declarations and edges, some noise
    task automatic build_graph(input int n, input int edges_per);
        int e;
        send(MODE_RESET, 0, 0, 0, n);
        for (int v = 0; v < n; v++) begin
            send(MODE_DECLARE, v, $urandom_range(99) < 85, 0, 0);
            e = $urandom_range(edges_per);
            for (int k = 0; k < e; k++) begin
                if ($urandom_range(99) < 5)
                    send(MODE_ADD, 0, 0, $urandom_range(255), 0);
                else
                    send(MODE_ADD, 0, 0, $urandom_range(n - 1), 0);
            end
        end
        send(MODE_COMPUTE, 0, 0, 0, 0);
        for (int k = 0; k < 4; k++)
            send(MODE_QUERY, $urandom_range(n + 1 > 255 ? 255 : n + 1), 0, 0, 0);
        if ($urandom_range(99) < 20)
            send(3'($urandom_range(7)), $urandom_range(255), $urandom_range(1),
                 $urandom_range(255), $urandom_range(511));
    endtask

    initial begin
        i_rst_n  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = MODE_RESET;
        m_tready = 0;
        calm     = 0;
        sent     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: bow tie (two triangles sharing node 2), parallel edge,
        // self loop, range errors, unused modes
        send(MODE_QUERY, 0, 0, 0, 0);
        send(MODE_RESET, 0, 0, 0, 511);
        send(MODE_RESET, 0, 0, 0, 6);
        send(MODE_ADD, 0, 0, 1, 0);
        send(MODE_DECLARE, 0, 1, 0, 0);  send(MODE_ADD, 0, 0, 1, 0);
        send(MODE_ADD, 0, 0, 2, 0);
        send(MODE_DECLARE, 1, 1, 0, 0);  send(MODE_ADD, 0, 0, 2, 0);
        send(MODE_DECLARE, 2, 1, 0, 0);  send(MODE_ADD, 0, 0, 3, 0);
        send(MODE_ADD, 0, 0, 4, 0);      send(MODE_ADD, 0, 0, 2, 0);
        send(MODE_DECLARE, 3, 1, 0, 0);  send(MODE_ADD, 0, 0, 4, 0);
        send(MODE_DECLARE, 4, 1, 0, 0);  send(MODE_ADD, 0, 0, 5, 0);
        send(MODE_ADD, 0, 0, 5, 0);
        send(MODE_DECLARE, 255, 1, 0, 0);
        send(MODE_ADD, 0, 0, 255, 0);
        send(MODE_COMPUTE, 0, 0, 0, 0);
        send(MODE_QUERY, 2, 0, 0, 0);
        send(MODE_QUERY, 4, 0, 0, 0);
        send(3'd5, 0, 0, 0, 0); send(3'd6, 0, 0, 0, 0); send(3'd7, 255, 1, 255, 511);

        // full size graph with no idling on either side
        calm = 1;
        build_graph(256, 3);
        calm = 0;

        // random graphs, mostly small
        while (sent < 1500) begin
            if ($urandom_range(99) < 4) build_graph(256, 3);
            else build_graph($urandom_range(2, 24), 4);
        end
        s_tvalid <= 0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
